// File: hdl/indexed_list_insert_erase_macros.svh
// Assertion helpers for the indexed list block.
// All of them sample on clk and are off while rst is high.
`ifndef INDEXED_LIST_INSERT_ERASE_MACROS_SVH
`define INDEXED_LIST_INSERT_ERASE_MACROS_SVH

// Same-cycle implication.
`define ILIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ILIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ilie_pkg.sv
package ilie_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int TYPE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_READ   = 3'd4,
    REQ_WRITE  = 3'd5,
    REQ_RESIZE = 3'd6
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Memory work that a request needs from the sequencer
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_PUSH,
    MOP_WRITE,
    MOP_READ,
    MOP_INSERT,
    MOP_ERASE
  } mop_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC,
    CNT_LOAD
  } cnt_op_t;

  typedef struct packed {
    status_t status;
    cnt_op_t cnt_op;
    mop_t    mop;
  } act_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_st_t;

endpackage

// File: hdl/ilie_channels.sv
interface ilie_req_if import ilie_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface ilie_rsp_if import ilie_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  read_value;
  logic [COUNT_W-1:0]  count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, read_value, count, status, input ready);
  modport sink   (input valid, read_value, count, status, output ready);
endinterface

// File: hdl/ilie_dec.sv
module ilie_dec import ilie_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int PW = (CW > POS_W) ? CW : POS_W
) (
  input  logic [TYPE_W-1:0] req_type,
  input  logic [POS_W-1:0]  position,
  input  logic [CW-1:0]     count,
  output act_t              act
);

  logic [PW-1:0] pe;
  logic [PW-1:0] ce;
  logic          full;

  assign pe   = PW'(position);
  assign ce   = PW'(count);
  assign full = (count == CW'(DEPTH));

  always_comb begin
    act = '{status: ST_OK, cnt_op: CNT_KEEP, mop: MOP_NONE};
    case (req_type)
      REQ_PUSH: begin
        if (full) begin
          act.status = ST_FULL;
        end else begin
          act.mop    = MOP_PUSH;
          act.cnt_op = CNT_INC;
        end
      end
      REQ_POP: begin
        if (count == '0) begin
          act.status = ST_EMPTY;
        end else begin
          act.cnt_op = CNT_DEC;
        end
      end
      REQ_INSERT: begin
        // range is checked before capacity
        if (pe > ce) begin
          act.status = ST_RANGE;
        end else if (full) begin
          act.status = ST_FULL;
        end else begin
          act.mop    = MOP_INSERT;
          act.cnt_op = CNT_INC;
        end
      end
      REQ_ERASE: begin
        if (pe >= ce) begin
          act.status = ST_RANGE;
        end else begin
          act.mop    = MOP_ERASE;
          act.cnt_op = CNT_DEC;
        end
      end
      REQ_READ: begin
        if (pe >= ce) begin
          act.status = ST_RANGE;
        end else begin
          act.mop = MOP_READ;
        end
      end
      REQ_WRITE: begin
        if (pe >= ce) begin
          act.status = ST_RANGE;
        end else begin
          act.mop = MOP_WRITE;
        end
      end
      REQ_RESIZE: begin
        if (pe > PW'(DEPTH)) begin
          act.status = ST_RANGE;
        end else begin
          act.cnt_op = CNT_LOAD;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/ilie_seq.sv
module ilie_seq import ilie_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int PW = (CW > POS_W) ? CW : POS_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mop_t                  mop,
  input  logic [POS_W-1:0]      position,
  input  logic [CW-1:0]         count,
  input  logic [WORD_WIDTH-1:0] value,
  input  logic                  out_free,
  output seq_st_t               st,
  output logic [WORD_WIDTH-1:0] rd_word
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_SHIFT,
    S_PUTW,
    S_FINISH
  } state_t;

  state_t                state;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         lim;
  logic                  up;
  logic [AW-1:0]         put_addr;
  logic [WORD_WIDTH-1:0] word;

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] q;

  logic                  we;
  logic [AW-1:0]         wa;
  logic [WORD_WIDTH-1:0] wd;
  logic                  re;
  logic [AW-1:0]         ra;

  logic [PW-1:0]         pe;
  logic [PW-1:0]         pos_p1;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         pos_a;
  logic [AW-1:0]         nxt_a;
  logic [AW-1:0]         cnt_a;
  logic [AW-1:0]         last_a;
  logic                  ins_at_end;
  logic                  ers_shift;
  logic [AW-1:0]         idx_up;
  logic [AW-1:0]         idx_dn;

  assign pe         = PW'(position);
  assign pos_p1     = pe + PW'(1);
  assign cnt_m1     = count - CW'(1);
  assign pos_a      = pe[AW-1:0];
  assign nxt_a      = pos_p1[AW-1:0];
  assign cnt_a      = count[AW-1:0];
  assign last_a     = cnt_m1[AW-1:0];
  assign ins_at_end = (pe == PW'(count));
  assign ers_shift  = (pos_p1 != PW'(count));
  assign idx_up     = idx + AW'(1);
  assign idx_dn     = idx - AW'(1);

  assign st.idle = (state == S_IDLE);
  assign st.done = (state == S_FINISH) && out_free;

  // Port steering. During a shift the read runs two entries ahead of the
  // write, so the two never hit the same entry.
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = value;
    re = 1'b0;
    ra = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = idx;
        wd = '0;
      end
      S_IDLE: begin
        if (start) begin
          case (mop)
            MOP_PUSH: begin
              we = 1'b1;
              wa = cnt_a;
            end
            MOP_WRITE: begin
              we = 1'b1;
              wa = pos_a;
            end
            MOP_READ: begin
              re = 1'b1;
              ra = pos_a;
            end
            MOP_INSERT: begin
              if (ins_at_end) begin
                we = 1'b1;
                wa = pos_a;
              end else begin
                re = 1'b1;
                ra = last_a;
              end
            end
            MOP_ERASE: begin
              re = ers_shift;
              ra = nxt_a;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        wa = up ? idx_up : idx_dn;
        wd = q;
        re = (idx != lim);
        ra = up ? idx_dn : idx_up;
      end
      S_PUTW: begin
        we = 1'b1;
        wa = put_addr;
        wd = word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          idx <= idx_up;
          if (idx == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            rd_word <= '0;
            case (mop)
              MOP_READ: begin
                state <= S_RDWAIT;
              end
              MOP_INSERT: begin
                if (ins_at_end) begin
                  state <= S_FINISH;
                end else begin
                  state    <= S_SHIFT;
                  idx      <= last_a;
                  lim      <= pos_a;
                  up       <= 1'b1;
                  put_addr <= pos_a;
                  word     <= value;
                end
              end
              MOP_ERASE: begin
                if (ers_shift) begin
                  state <= S_SHIFT;
                  idx   <= nxt_a;
                  lim   <= last_a;
                  up    <= 1'b0;
                end else begin
                  state <= S_FINISH;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          rd_word <= q;
          state   <= S_FINISH;
        end
        S_SHIFT: begin
          if (idx == lim) begin
            state <= up ? S_PUTW : S_FINISH;
          end else begin
            idx <= up ? idx_dn : idx_up;
          end
        end
        S_PUTW: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/indexed_list_insert_erase.sv
// Bounded positional list of DEPTH words with a live count.
// Request channel (req): req_type, position, value. Response channel (rsp):
// read_value, count, status. Both use valid/ready; a transaction completes
// when both are high at a rising clk edge. Each request gives one response.
// Steps per request: push, pop, write, resize and a failed or unused request
// go straight to the response; a read first waits for the memory word; an
// insert below the end shifts the entries from position up by one and then
// writes the new word, and an erase below the last entry shifts the entries
// above position down by one. One request is in flight at a time; the rate
// is set by the shift loop of the sequencer, one entry per cycle.
// The response sits in an output register: the next request is taken while
// an earlier response still waits. When rsp is stalled, a finished request
// holds in the sequencer until the output register frees up.
// Reset (rst, synchronous) zeroes the count and starts a clearing pass that
// writes zero to every entry, with req.ready low meanwhile.
`include "indexed_list_insert_erase_macros.svh"

module indexed_list_insert_erase import ilie_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ilie_req_if.sink  req,
  ilie_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]         live_count;
  logic [CW-1:0]         new_count;
  logic [COUNT_W-1:0]    new_count_o;
  logic [PW-1:0]         pe;
  act_t                  act;
  seq_st_t               seq_st;
  logic                  accept;
  logic                  out_free;
  logic [WORD_WIDTH-1:0] value_w;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [VALUE_W-1:0]    rd_out;

  logic [COUNT_W-1:0]    pend_count;
  status_t               pend_status;
  logic                  out_valid;
  logic [VALUE_W-1:0]    out_rd;
  logic [COUNT_W-1:0]    out_count;
  status_t               out_status;

  assign req.ready = seq_st.idle;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_rd;
  assign rsp.count      = out_count;
  assign rsp.status     = out_status;

  if (WORD_WIDTH <= VALUE_W) begin : g_narrow
    assign value_w = req.value[WORD_WIDTH-1:0];
    assign rd_out  = VALUE_W'(rd_word);
  end else begin : g_wide
    assign value_w = {{(WORD_WIDTH - VALUE_W){1'b0}}, req.value};
    assign rd_out  = rd_word[VALUE_W-1:0];
  end

  if (CW >= COUNT_W) begin : g_cnt_trunc
    assign new_count_o = new_count[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign new_count_o = {{(COUNT_W - CW){1'b0}}, new_count};
  end

  assign pe = PW'(req.position);

  always_comb begin
    case (act.cnt_op)
      CNT_INC:  new_count = live_count + CW'(1);
      CNT_DEC:  new_count = live_count - CW'(1);
      CNT_LOAD: new_count = pe[CW-1:0];
      default:  new_count = live_count;
    endcase
  end

  ilie_dec #(
    .DEPTH (DEPTH)
  ) u_dec (
    .req_type (req.req_type),
    .position (req.position),
    .count    (live_count),
    .act      (act)
  );

  ilie_seq #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .mop      (act.mop),
    .position (req.position),
    .count    (live_count),
    .value    (value_w),
    .out_free (out_free),
    .st       (seq_st),
    .rd_word  (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        live_count <= new_count;
      end
      if (seq_st.done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_count  <= new_count_o;
      pend_status <= act.status;
    end
    if (seq_st.done) begin
      out_rd     <= rd_out;
      out_count  <= pend_count;
      out_status <= pend_status;
    end
  end

  `ILIE_ASSERT_NOW(a_count_bound, 1'b1, live_count <= CW'(DEPTH), "live count above depth")
  `ILIE_ASSERT_NXT(a_one_in_flight, accept, !req.ready, "request taken while busy")
  `ILIE_ASSERT_NXT(a_err_keeps_count, accept && (act.status != ST_OK), live_count == $past(live_count), "failed request changed count")
  `ILIE_ASSERT_NOW(a_done_free, seq_st.done, !out_valid || rsp.ready, "response overwrote pending one")

endmodule
